FILE: rtl/byte_diff_run_encoder_macros.svh
// Assertion macros shared by the byte diff run encoder.
`ifndef BYTE_DIFF_RUN_ENCODER_MACROS_SVH
`define BYTE_DIFF_RUN_ENCODER_MACROS_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define BDRE_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define BDRE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/bdre_pkg.sv
// Types and constants of the byte diff run encoder.
package bdre_pkg;

  localparam int unsigned BLOCK_BYTES   = 4096;
  localparam int unsigned HEADER_BYTES  = 8;
  localparam int unsigned FIFO_DEPTH    = 8;
  localparam int unsigned ADDR_W        = 16;
  localparam int unsigned POS_W         = 13;
  localparam int unsigned OFF_W         = 12;
  localparam int unsigned LEN_W         = 13;
  localparam int unsigned MAX_RESULTS   = 3;
  localparam logic [15:0] BUDGET_RESET  = 16'd8192;

  typedef enum logic [1:0] {
    KIND_DATA     = 2'd0,
    KIND_HEADER   = 2'd1,
    KIND_DONE     = 2'd2,
    KIND_OVERFLOW = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ADDR_W-1:0]  addr;
    logic [OFF_W-1:0]   run_offset;
    logic [LEN_W-1:0]   run_length;
    logic [7:0]         data_value;
    logic [ADDR_W-1:0]  total_size;
    logic               last;
  } res_t;

  // Results caused by one accepted pair, packed from slot 0 upward.
  typedef struct packed {
    logic [1:0]                 n;
    res_t [MAX_RESULTS-1:0]     slot;
  } push_t;

endpackage

FILE: rtl/bdre_core.sv
// Run tracking state and per-pair result generation.
module bdre_core import bdre_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] budget_i,
  input  logic        fire_i,
  input  logic [7:0]  cur_i,
  input  logic [7:0]  twin_i,
  input  logic        last_i,
  output push_t       push_o
);

  localparam logic [POS_W-1:0] PosLast = POS_W'(BLOCK_BYTES - 1);

  logic              in_run_q, in_run_d;
  logic [POS_W-1:0]  pos_q, pos_d;
  logic [OFF_W-1:0]  run_start_q, run_start_d;
  logic [LEN_W-1:0]  run_count_q, run_count_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic              ovf_q, ovf_d;

  logic              blk_last, differs, ovf_now, run_open, close;
  logic [LEN_W-1:0]  cnt, new_count;
  logic [OFF_W-1:0]  new_start;
  logic [ADDR_W+1:0] end_sum;
  logic [ADDR_W-1:0] data_addr, next_base;
  res_t [MAX_RESULTS-1:0] cand;
  logic [MAX_RESULTS-1:0] cand_v;

  always_comb begin
    blk_last  = last_i || (pos_q >= PosLast);
    differs   = cur_i != twin_i;
    cnt       = in_run_q ? run_count_q : '0;
    end_sum   = {2'b00, base_q} + (ADDR_W+2)'(HEADER_BYTES) + (ADDR_W+2)'(cnt)
                + (ADDR_W+2)'(1);
    ovf_now   = differs && (end_sum > {2'b00, budget_i});
    run_open  = in_run_q || differs;
    new_count = differs ? cnt + LEN_W'(1) : cnt;
    new_start = (!in_run_q && differs) ? pos_q[OFF_W-1:0] : run_start_q;
    close     = !ovf_q && !ovf_now && run_open && (!differs || blk_last);
    data_addr = base_q + ADDR_W'(HEADER_BYTES) + ADDR_W'(cnt);
    next_base = base_q + ADDR_W'(HEADER_BYTES) + ADDR_W'(new_count);
  end

  // Candidate results in emission order: data or overflow, header, done.
  always_comb begin
    logic [1:0] n;
    cand   = '0;
    cand_v = '0;
    cand_v[0] = !ovf_q && differs;
    cand[0].kind = ovf_now ? KIND_OVERFLOW : KIND_DATA;
    cand[0].addr = ovf_now ? base_q : data_addr;
    cand[0].data_value = ovf_now ? 8'd0 : cur_i;
    cand_v[1] = close;
    cand[1].kind       = KIND_HEADER;
    cand[1].addr       = base_q;
    cand[1].run_offset = new_start;
    cand[1].run_length = new_count;
    cand_v[2] = !ovf_q && !ovf_now && blk_last;
    cand[2].kind       = KIND_DONE;
    cand[2].addr       = close ? next_base : base_q;
    cand[2].total_size = close ? next_base : base_q;

    n = '0;
    push_o = '0;
    for (int k = 0; k < MAX_RESULTS; k++) begin
      if (cand_v[k]) begin
        push_o.slot[n] = cand[k];
        n = n + 2'd1;
      end
    end
    if (n != 2'd0) begin
      push_o.slot[n - 2'd1].last = 1'b1;
    end
    push_o.n = n;
  end

  always_comb begin
    in_run_d    = in_run_q;
    pos_d       = pos_q + POS_W'(1);
    run_start_d = run_start_q;
    run_count_d = run_count_q;
    base_d      = base_q;
    ovf_d       = ovf_q;
    if (blk_last) begin
      in_run_d    = 1'b0;
      pos_d       = '0;
      run_start_d = '0;
      run_count_d = '0;
      base_d      = '0;
      ovf_d       = 1'b0;
    end else if (!ovf_q) begin
      if (ovf_now) begin
        ovf_d    = 1'b1;
        in_run_d = 1'b0;
      end else if (close) begin
        in_run_d    = 1'b0;
        run_count_d = '0;
        run_start_d = new_start;
        base_d      = next_base;
      end else begin
        in_run_d    = run_open;
        run_count_d = new_count;
        run_start_d = new_start;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_run_q    <= 1'b0;
      pos_q       <= '0;
      run_start_q <= '0;
      run_count_q <= '0;
      base_q      <= '0;
      ovf_q       <= 1'b0;
    end else if (fire_i) begin
      in_run_q    <= in_run_d;
      pos_q       <= pos_d;
      run_start_q <= run_start_d;
      run_count_q <= run_count_d;
      base_q      <= base_d;
      ovf_q       <= ovf_d;
    end
  end

endmodule

FILE: rtl/bdre_result_fifo.sv
// Result queue that takes up to three results per cycle and gives one per cycle when popped.
module bdre_result_fifo import bdre_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_en_i,
  input  push_t                       push_i,
  input  logic                        pop_i,
  output res_t                        head_o,
  output logic                        valid_o,
  output logic                        ready_o,
  output logic [$clog2(Depth+1)-1:0]  count_o
);

  // Depth must be a power of two of at least four, so pointers wrap naturally; the block does not check it.
  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  res_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic [1:0]      push_n;
  logic            pop;

  always_comb begin
    push_n   = push_en_i ? push_i.n : 2'd0;
    pop      = pop_i && valid_o;
    wr_ptr_d = wr_ptr_q + PtrW'(push_n);
    rd_ptr_d = rd_ptr_q + PtrW'(pop);
    count_d  = count_q + CntW'(push_n) - CntW'(pop);
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = count_q != '0;
  assign ready_o = count_q <= CntW'(Depth - MAX_RESULTS);
  assign count_o = count_q;

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (2'(i) < push_n) begin
        mem_q[wr_ptr_q + PtrW'(i)] <= push_i.slot[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

FILE: rtl/byte_diff_run_encoder.sv
// Top level of the byte diff run encoder.
//
// The slave stream carries one byte pair per request: the current byte and
// its twin, with tlast marking the final pair of the block. Every pair is
// compared in the cycle it is accepted; each maximal run of differing bytes
// becomes a record of a header slot followed by the current bytes of the run.
// The master stream gives one result per request: tuser holds the kind (data,
// header, done, overflow) and tlast marks the last result caused by a pair.
// A data byte appears at its buffer address right away, its header when the
// run closes, and the done result with the block's last pair. A record that
// would pass output_budget gives one overflow result and mutes the block.
// Results of an accepted pair are registered in the result queue. One pair is
// taken per cycle while the result queue keeps room for three results; the
// master side drains one result per cycle while tready is high, so pairs that
// cause two or three results slow the input to match the output rate.
// The budget register is written through cfg_we_i and cfg_wdata_i and resets
// to 8192. Reset empties the queue and starts a fresh block. When the
// receiver stalls, results wait in the queue and tready falls once fewer
// than three free entries remain.
`include "byte_diff_run_encoder_macros.svh"

module byte_diff_run_encoder import bdre_pkg::*; #(
  parameter int unsigned FifoDepth = FIFO_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // Fields from bit 0 up: current_byte [7:0], twin_byte [15:8].
  input  logic [15:0] s_axis_tdata,
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // Fields from bit 0 up: out_address [15:0], run_offset [27:16],
  // run_length [40:28], data_value [48:41], total_size [64:49], zero fill.
  output logic [71:0] m_axis_tdata,
  // Fields from bit 0 up: kind [1:0].
  output logic [1:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  logic [15:0]     budget_q;
  logic            s_fire;
  push_t           push;
  res_t            head;
  logic [CntW-1:0] fifo_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= BUDGET_RESET;
    end else if (cfg_we_i) begin
      budget_q <= cfg_wdata_i;
    end
  end

  assign s_fire = s_axis_tvalid && s_axis_tready;

  bdre_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .budget_i (budget_q),
    .fire_i   (s_fire),
    .cur_i    (s_axis_tdata[7:0]),
    .twin_i   (s_axis_tdata[15:8]),
    .last_i   (s_axis_tlast),
    .push_o   (push)
  );

  bdre_result_fifo #(
    .Depth (FifoDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (s_fire),
    .push_i    (push),
    .pop_i     (m_axis_tready),
    .head_o    (head),
    .valid_o   (m_axis_tvalid),
    .ready_o   (s_axis_tready),
    .count_o   (fifo_count)
  );

  assign m_axis_tdata = {7'b0, head.total_size, head.data_value, head.run_length,
                         head.run_offset, head.addr};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

  // The queue never holds more results than it has entries.
  `BDRE_ASSERT_IMP(a_count_bound, 1'b1, fifo_count <= CntW'(FifoDepth), "result queue overrun")
  // An overflow result is always the only result of its pair.
  `BDRE_ASSERT_IMP(a_ovf_alone, s_fire && (push.n != 2'd0) && (push.slot[0].kind == KIND_OVERFLOW), push.n == 2'd1, "overflow shares a pair with other results")
  // A push of results makes the master side valid in the next cycle.
  `BDRE_ASSERT_NEXT(a_push_shows, s_fire && (push.n != 2'd0), m_axis_tvalid, "pushed result not offered")

endmodule
